// File: rtl/owrlm_pkg.sv
// shared types and constants for the weighted random-list matcher
package owrlm_pkg;

    // field widths
    localparam int V_W   = 10;
    localparam int W_W   = 17;
    localparam int R_W   = 16;
    localparam int CNT_W = 2;

    // shared multiplier operand and product widths
    localparam int MOP_W  = 18;
    localparam int PROD_W = 34;

    // divider widths: dividend is the product padded to twice the quotient width
    localparam int DEN_W     = 18;
    localparam int Q_W       = 18;
    localparam int DIVD_W    = 2 * Q_W;
    localparam int DIV_STEPS = Q_W / 2;
    localparam int DIV_CNT_W = 4;

    // running sum of six terms, each below 2^17
    localparam int SUM_W = 20;

    // taken-map epoch tag
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

    // three-candidate orders, taken in this sequence
    localparam int N_ORDERS = 6;
    localparam logic [2:0] LAST_ORDER = 3'(N_ORDERS - 1);
    localparam logic [1:0] ORDER_A [N_ORDERS] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
    localparam logic [1:0] ORDER_B [N_ORDERS] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1};
    localparam logic [1:0] ORDER_C [N_ORDERS] = '{2'd2, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0};

    // candidate counts
    localparam logic [CNT_W-1:0] CNT_NONE  = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONE   = 2'd1;
    localparam logic [CNT_W-1:0] CNT_TWO   = 2'd2;
    localparam logic [CNT_W-1:0] CNT_THREE = 2'd3;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DEN_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: rtl/owrlm_div.sv
// radix-4 restoring divider, two quotient bits per cycle
module owrlm_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  owrlm_pkg::div_req_t req,
    output owrlm_pkg::div_rsp_t rsp
);

    logic                                run_reg, run_next;
    logic                                done_reg, done_next;
    logic [owrlm_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [owrlm_pkg::DEN_W-1:0]         rem_reg, rem_next;
    logic [owrlm_pkg::Q_W-1:0]           low_reg, low_next;
    logic [owrlm_pkg::Q_W-1:0]           quo_reg, quo_next;
    logic [owrlm_pkg::DEN_W-1:0]         den_reg, den_next;
    logic [owrlm_pkg::DEN_W:0]           step_hi;
    logic [owrlm_pkg::DEN_W:0]           step_lo;

    // one compare-subtract; result is {quotient bit, new remainder}
    function automatic logic [owrlm_pkg::DEN_W:0] div_step(
        input logic [owrlm_pkg::DEN_W-1:0] rem,
        input logic                        bit_in,
        input logic [owrlm_pkg::DEN_W-1:0] den
    );
        logic [owrlm_pkg::DEN_W:0] trial;
        begin
            trial = {rem, bit_in};
            if (trial >= {1'b0, den})
            begin
                div_step = {1'b1, owrlm_pkg::DEN_W'(trial - {1'b0, den})};
            end
            else
            begin
                div_step = {1'b0, trial[owrlm_pkg::DEN_W-1:0]};
            end
        end
    endfunction

    // two dependent steps per cycle
    assign step_hi = div_step(rem_reg, low_reg[owrlm_pkg::Q_W-1], den_reg);
    assign step_lo = div_step(step_hi[owrlm_pkg::DEN_W-1:0], low_reg[owrlm_pkg::Q_W-2],
                              den_reg);

    // next-state logic
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = owrlm_pkg::DIV_CNT_W'(owrlm_pkg::DIV_STEPS - 1);
            rem_next = req.dividend[owrlm_pkg::DIVD_W-1:owrlm_pkg::Q_W];
            low_next = req.dividend[owrlm_pkg::Q_W-1:0];
            quo_next = '0;
            den_next = req.divisor;
        end
        else if (run_reg)
        begin
            rem_next = step_lo[owrlm_pkg::DEN_W-1:0];
            low_next = {low_reg[owrlm_pkg::Q_W-3:0], 2'b00};
            quo_next = {quo_reg[owrlm_pkg::Q_W-3:0], step_hi[owrlm_pkg::DEN_W],
                        step_lo[owrlm_pkg::DEN_W]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: rtl/online_weighted_random_list_matcher.sv
// top level: list choice, shared multiplier and divider, taken-map memory
//
// Command port: an arrival transfers on a rising edge with start high and busy
// low. All candidate fields and random_sample are captured at that edge.
// One result per arrival: done is high for exactly one cycle with got_match
// and matched_vertex; the receiver has no way to hold it off.
// Three candidates cost up to six terms, each taking a product on the shared
// 18x18 multiplier, a start of the radix-4 divider, then a wait while its 9
// iterations run; a term with a zero denominator skips the multiplier and
// divider. The list walk then does a memory read and check per candidate
// within range.
// busy falls in the cycle done is high, so the next arrival can transfer then.
// The taken map is a VERTICES x 8 memory of epoch tags; a first arrival
// moves to a new epoch. Once every 255 first arrivals the epoch wraps and
// the memory is swept before that arrival is handled.
// After reset the block sweeps the memory with busy high
// and accepts no arrival until the sweep ends.
module online_weighted_random_list_matcher
#(
    parameter int VERTICES = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          first_arrival,
    input  logic [owrlm_pkg::CNT_W-1:0]   cand_count,
    input  logic [owrlm_pkg::V_W-1:0]     vertex_first,
    input  logic [owrlm_pkg::V_W-1:0]     vertex_second,
    input  logic [owrlm_pkg::V_W-1:0]     vertex_third,
    input  logic [owrlm_pkg::W_W-1:0]     weight_first,
    input  logic [owrlm_pkg::W_W-1:0]     weight_second,
    input  logic [owrlm_pkg::W_W-1:0]     weight_third,
    input  logic [owrlm_pkg::R_W-1:0]     random_sample,
    output logic                          done,
    output logic                          got_match,
    output logic [owrlm_pkg::V_W-1:0]     matched_vertex
);

    localparam int AW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(VERTICES - 1);
    localparam logic [16:0]   VTX_LIM   = 17'(VERTICES);

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_PREP  = 10'b0000000100,
        ST_SEL2  = 10'b0000001000,
        ST_CMP2  = 10'b0000010000,
        ST_MUL   = 10'b0000100000,
        ST_DIVGO = 10'b0001000000,
        ST_DIV   = 10'b0010000000,
        ST_LOOK  = 10'b0100000000,
        ST_CHECK = 10'b1000000000
    } state_t;

    state_t                                state_reg, state_next;
    logic [owrlm_pkg::EPOCH_W-1:0]         epoch_reg, epoch_next;
    logic                                  clr_item_reg, clr_item_next;
    logic [AW-1:0]                         clr_cnt_reg, clr_cnt_next;
    logic                                  done_reg, done_next;
    logic                                  got_reg, got_next;
    logic [owrlm_pkg::V_W-1:0]             mv_reg, mv_next;

    // captured arrival
    logic [owrlm_pkg::CNT_W-1:0]           cnt_reg, cnt_next;
    logic [owrlm_pkg::V_W-1:0]             v_reg [3];
    logic [owrlm_pkg::V_W-1:0]             v_next [3];
    logic [owrlm_pkg::W_W-1:0]             w_reg [3];
    logic [owrlm_pkg::W_W-1:0]             w_next [3];
    logic [owrlm_pkg::R_W-1:0]             r_reg, r_next;

    // list choice datapath
    logic [2:0]                            k_reg, k_next;
    logic [owrlm_pkg::SUM_W-1:0]           sum_reg, sum_next;
    logic [owrlm_pkg::PROD_W-1:0]          prod_reg, prod_next;
    logic [owrlm_pkg::DEN_W-1:0]           den_reg, den_next;
    logic [owrlm_pkg::V_W-1:0]             list_reg [3];
    logic [owrlm_pkg::V_W-1:0]             list_next [3];
    logic [1:0]                            len_reg, len_next;
    logic [1:0]                            pos_reg, pos_next;

    logic [owrlm_pkg::MOP_W-1:0]           mul_a;
    logic [owrlm_pkg::MOP_W-1:0]           mul_b;
    logic [2*owrlm_pkg::MOP_W-1:0]         mul_p;
    logic                                  acc_en;
    logic [owrlm_pkg::Q_W-1:0]             term;
    logic [owrlm_pkg::SUM_W-1:0]           sum_acc;
    logic [1:0]                            ia, ib, ic;
    logic [owrlm_pkg::V_W-1:0]             cur_v;

    owrlm_pkg::div_req_t                   div_req;
    owrlm_pkg::div_rsp_t                   div_rsp;

    // taken-map memory
    logic [owrlm_pkg::EPOCH_W-1:0]         taken_mem [VERTICES];
    logic [owrlm_pkg::EPOCH_W-1:0]         rd_data_reg;
    logic                                  mem_we;
    logic [AW-1:0]                         mem_waddr;
    logic [owrlm_pkg::EPOCH_W-1:0]         mem_wdata;
    logic                                  mem_re;
    logic [AW-1:0]                         mem_raddr;

    owrlm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // shared multiplier
    assign mul_p = mul_a * mul_b;

    // order lookup and current list entry
    assign ia      = owrlm_pkg::ORDER_A[k_reg];
    assign ib      = owrlm_pkg::ORDER_B[k_reg];
    assign ic      = owrlm_pkg::ORDER_C[k_reg];
    assign cur_v   = list_reg[pos_reg];
    assign sum_acc = sum_reg + owrlm_pkg::SUM_W'(term);

    // control and datapath next-state
    always_comb
    begin
        state_next    = state_reg;
        epoch_next    = epoch_reg;
        clr_item_next = clr_item_reg;
        clr_cnt_next  = clr_cnt_reg;
        done_next     = 1'b0;
        got_next      = got_reg;
        mv_next       = mv_reg;
        cnt_next      = cnt_reg;
        v_next        = v_reg;
        w_next        = w_reg;
        r_next        = r_reg;
        k_next        = k_reg;
        sum_next      = sum_reg;
        prod_next     = prod_reg;
        den_next      = den_reg;
        list_next     = list_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        mul_a         = '0;
        mul_b         = '0;
        acc_en        = 1'b0;
        term          = '0;
        mem_we        = 1'b0;
        mem_waddr     = clr_cnt_reg;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = AW'(cur_v);
        div_req.start    = 1'b0;
        div_req.dividend = owrlm_pkg::DIVD_W'(prod_reg);
        div_req.divisor  = den_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    epoch_next    = owrlm_pkg::EPOCH_FIRST;
                    clr_item_next = 1'b0;
                    clr_cnt_next  = '0;
                    state_next    = clr_item_reg ? ST_PREP : ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cnt_next  = cand_count;
                    v_next[0] = vertex_first;
                    v_next[1] = vertex_second;
                    v_next[2] = vertex_third;
                    w_next[0] = weight_first;
                    w_next[1] = weight_second;
                    w_next[2] = weight_third;
                    r_next    = random_sample;
                    state_next = ST_PREP;
                    // new epoch, or a sweep when the tag would wrap
                    if (first_arrival)
                    begin
                        if (epoch_reg == owrlm_pkg::EPOCH_MAX)
                        begin
                            clr_item_next = 1'b1;
                            clr_cnt_next  = '0;
                            state_next    = ST_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                    end
                end
            end
            ST_PREP:
            begin
                pos_next = '0;
                sum_next = '0;
                k_next   = '0;
                unique case (cnt_reg)
                    owrlm_pkg::CNT_NONE:
                    begin
                        len_next   = 2'd0;
                        state_next = ST_LOOK;
                    end
                    owrlm_pkg::CNT_ONE:
                    begin
                        list_next[0] = v_reg[0];
                        len_next     = 2'd1;
                        state_next   = ST_LOOK;
                    end
                    owrlm_pkg::CNT_TWO:
                    begin
                        state_next = ST_SEL2;
                    end
                    owrlm_pkg::CNT_THREE:
                    begin
                        state_next = ST_MUL;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SEL2:
            begin
                mul_a      = owrlm_pkg::MOP_W'(r_reg);
                mul_b      = owrlm_pkg::MOP_W'(w_reg[0]) + owrlm_pkg::MOP_W'(w_reg[1]);
                prod_next  = mul_p[owrlm_pkg::PROD_W-1:0];
                state_next = ST_CMP2;
            end
            ST_CMP2:
            begin
                // first candidate leads when r*(w1+w2) <= w1*65536
                if (prod_reg <= {1'b0, w_reg[0], 16'b0})
                begin
                    list_next[0] = v_reg[0];
                    list_next[1] = v_reg[1];
                end
                else
                begin
                    list_next[0] = v_reg[1];
                    list_next[1] = v_reg[0];
                end
                len_next   = 2'd2;
                state_next = ST_LOOK;
            end
            ST_MUL:
            begin
                // zero denominator counts as a zero term
                if (w_reg[ib] == '0 && w_reg[ic] == '0)
                begin
                    acc_en = 1'b1;
                end
                else
                begin
                    mul_a      = owrlm_pkg::MOP_W'(w_reg[ia]);
                    mul_b      = owrlm_pkg::MOP_W'(w_reg[ib]);
                    prod_next  = mul_p[owrlm_pkg::PROD_W-1:0];
                    den_next   = owrlm_pkg::DEN_W'(w_reg[ib]) + owrlm_pkg::DEN_W'(w_reg[ic]);
                    state_next = ST_DIVGO;
                end
            end
            ST_DIVGO:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    acc_en = 1'b1;
                    term   = div_rsp.quotient;
                end
            end
            ST_LOOK:
            begin
                if (pos_reg == len_reg)
                begin
                    done_next  = 1'b1;
                    got_next   = 1'b0;
                    mv_next    = '0;
                    state_next = ST_IDLE;
                end
                else if ({7'b0, cur_v} >= VTX_LIM)
                begin
                    pos_next = pos_reg + 1'b1;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // an entry is taken only when tagged with the current epoch
                if (rd_data_reg != epoch_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = AW'(cur_v);
                    mem_wdata  = epoch_reg;
                    done_next  = 1'b1;
                    got_next   = 1'b1;
                    mv_next    = cur_v;
                    state_next = ST_IDLE;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_LOOK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // accumulate a term and test the running sum
        if (acc_en)
        begin
            sum_next = sum_acc;
            if (sum_acc >= owrlm_pkg::SUM_W'(r_reg))
            begin
                list_next[0] = v_reg[ia];
                list_next[1] = v_reg[ib];
                list_next[2] = v_reg[ic];
                len_next     = 2'd3;
                pos_next     = '0;
                state_next   = ST_LOOK;
            end
            else if (k_reg == owrlm_pkg::LAST_ORDER)
            begin
                len_next   = 2'd0;
                pos_next   = '0;
                state_next = ST_LOOK;
            end
            else
            begin
                k_next     = k_reg + 1'b1;
                state_next = ST_MUL;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            epoch_reg    <= owrlm_pkg::EPOCH_FIRST;
            clr_item_reg <= 1'b0;
            clr_cnt_reg  <= '0;
            done_reg     <= 1'b0;
            k_reg        <= '0;
            len_reg      <= '0;
            pos_reg      <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            epoch_reg    <= epoch_next;
            clr_item_reg <= clr_item_next;
            clr_cnt_reg  <= clr_cnt_next;
            done_reg     <= done_next;
            k_reg        <= k_next;
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            cnt_reg      <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        got_reg   <= got_next;
        mv_reg    <= mv_next;
        v_reg     <= v_next;
        w_reg     <= w_next;
        r_reg     <= r_next;
        sum_reg   <= sum_next;
        prod_reg  <= prod_next;
        den_reg   <= den_next;
        list_reg  <= list_next;
    end

    // taken-map memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            taken_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= taken_mem[mem_raddr];
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign got_match      = got_reg;
    assign matched_vertex = mv_reg;

endmodule

// File: rtl/owrlm_chk.sv
// port checker for the weighted random-list matcher, bound to the top level
module owrlm_chk
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic                        got_match,
    input logic [owrlm_pkg::V_W-1:0]   matched_vertex
);

    // a transfer in always starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted arrival did not raise busy");

    // a result ends the work of its arrival
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result not at the end of a busy period");

    // no match reports vertex zero
    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !got_match |-> matched_vertex == '0)
        else $error("non-zero vertex without a match");

    // one cycle per result
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

bind online_weighted_random_list_matcher owrlm_chk u_owrlm_chk
(
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .got_match      (got_match),
    .matched_vertex (matched_vertex)
);

// File: tb/tb_top.sv
// testbench for the weighted random-list matcher: directed table, then random arrival sequences
module tb_top;

    import owrlm_pkg::*;

    localparam int VERTICES        = 1024;
    localparam int N_DIRECTED      = 23;
    localparam int N_PHASES        = 4;
    localparam int ITEMS_PER_PHASE = 440;
    localparam int DRAIN_CYCLES    = 100;
    localparam int EXP_DEPTH       = 4096;

    // the six three-candidate orders, in the order they are tried
    localparam int CAND_ORDERS [6][3] = '{
        '{0, 1, 2}, '{0, 2, 1}, '{1, 0, 2}, '{1, 2, 0}, '{2, 0, 1}, '{2, 1, 0}
    };

    // percentage of arrivals preceded by a sender gap, per phase
    // (the result side cannot stall; phases 0 and 2 run without gaps)
    localparam int IDLE_PCT [N_PHASES] = '{0, 75, 0, 36};

    typedef struct packed {
        logic             first_arrival;
        logic [CNT_W-1:0] cand_count;
        logic [V_W-1:0]   vertex_first;
        logic [V_W-1:0]   vertex_second;
        logic [V_W-1:0]   vertex_third;
        logic [W_W-1:0]   weight_first;
        logic [W_W-1:0]   weight_second;
        logic [W_W-1:0]   weight_third;
        logic [R_W-1:0]   random_sample;
    } arrival_t;

    typedef struct packed {
        logic           got_match;
        logic [V_W-1:0] matched_vertex;
    } match_t;

    typedef struct packed {
        arrival_t arrival;
        logic     fixed;
        match_t   outcome;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    arrival_t arr = '0;
    logic fixed_on = 1'b0;
    match_t fixed_outcome = '0;

    logic busy;
    logic done;
    logic got_match;
    logic [V_W-1:0] matched_vertex;

    // predictor state: which offline vertices are already matched
    logic [VERTICES-1:0] claimed = '0;
    // expected results in transfer order, written at exp_wr and read at exp_rd
    match_t expected_matches [EXP_DEPTH];
    int exp_wr = 0;
    int exp_rd = 0;
    int fails = 0;

    directed_row_t directed_rows [N_DIRECTED];

    online_weighted_random_list_matcher #(.VERTICES(VERTICES)) uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .first_arrival  (arr.first_arrival),
        .cand_count     (arr.cand_count),
        .vertex_first   (arr.vertex_first),
        .vertex_second  (arr.vertex_second),
        .vertex_third   (arr.vertex_third),
        .weight_first   (arr.weight_first),
        .weight_second  (arr.weight_second),
        .weight_third   (arr.weight_third),
        .random_sample  (arr.random_sample),
        .done           (done),
        .got_match      (got_match),
        .matched_vertex (matched_vertex)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // choose the preference list, then claim its first free vertex
    function automatic match_t predict_match(arrival_t a);
        logic [V_W-1:0] v [3];
        longint unsigned w [3];
        logic [V_W-1:0] pref [3];
        int list_len;
        longint unsigned r;
        longint unsigned run_sum;
        longint unsigned den;
        longint unsigned term;
        match_t m;
        int k;
        int ia;
        int ib;
        int ic;

        v[0] = a.vertex_first;
        v[1] = a.vertex_second;
        v[2] = a.vertex_third;
        w[0] = a.weight_first;
        w[1] = a.weight_second;
        w[2] = a.weight_third;
        r = a.random_sample;
        list_len = 0;
        run_sum = 0;
        m = '0;

        if (a.first_arrival)
            claimed = '0;

        if (a.cand_count == CNT_ONE)
        begin
            pref[0] = v[0];
            list_len = 1;
        end
        else if (a.cand_count == CNT_TWO)
        begin
            // exact comparison of r/65536 against w1/(w1+w2)
            if (r * (w[0] + w[1]) <= w[0] * 64'd65536)
            begin
                pref[0] = v[0];
                pref[1] = v[1];
            end
            else
            begin
                pref[0] = v[1];
                pref[1] = v[0];
            end
            list_len = 2;
        end
        else if (a.cand_count == CNT_THREE)
        begin
            // running sum of order weights until it reaches the sample
            for (k = 0; k < 6 && list_len == 0; k++)
            begin
                ia = CAND_ORDERS[k][0];
                ib = CAND_ORDERS[k][1];
                ic = CAND_ORDERS[k][2];
                den = w[ib] + w[ic];
                term = (den == 0) ? 64'd0 : (w[ia] * w[ib]) / den;
                run_sum += term;
                if (run_sum >= r)
                begin
                    pref[0] = v[ia];
                    pref[1] = v[ib];
                    pref[2] = v[ic];
                    list_len = 3;
                end
            end
        end

        // walk the list for the first unmatched vertex
        for (k = 0; k < list_len && !m.got_match; k++)
        begin
            if (int'(pref[k]) < VERTICES && !claimed[pref[k]])
            begin
                claimed[pref[k]] = 1'b1;
                m.got_match = 1'b1;
                m.matched_vertex = pref[k];
            end
        end
        return m;
    endfunction

    // result checking and prediction on each accepted transfer
    always @(posedge clk)
    begin
        match_t want;

        if (rst_n)
        begin
            if (done)
            begin
                if (exp_wr == exp_rd)
                begin
                    $error("result with no arrival outstanding: got_match %0d, matched_vertex %0d",
                        got_match, matched_vertex);
                    fails++;
                end
                else
                begin
                    want = expected_matches[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (got_match !== want.got_match)
                    begin
                        $error("got_match: expected %0d, got %0d", want.got_match, got_match);
                        fails++;
                    end
                    if (matched_vertex !== want.matched_vertex)
                    begin
                        $error("matched_vertex: expected %0d, got %0d",
                            want.matched_vertex, matched_vertex);
                        fails++;
                    end
                end
            end
            if (start && !busy)
            begin
                want = predict_match(arr);
                expected_matches[exp_wr % EXP_DEPTH] = fixed_on ? fixed_outcome : want;
                exp_wr++;
            end
        end
    end

    function automatic directed_row_t row(
        logic f, logic [CNT_W-1:0] c,
        logic [V_W-1:0] v1, logic [V_W-1:0] v2, logic [V_W-1:0] v3,
        logic [W_W-1:0] w1, logic [W_W-1:0] w2, logic [W_W-1:0] w3,
        logic [R_W-1:0] r, logic fx, logic g, logic [V_W-1:0] mv);
        directed_row_t d;

        d.arrival = '{f, c, v1, v2, v3, w1, w2, w3, r};
        d.fixed = fx;
        d.outcome = '{g, mv};
        return d;
    endfunction

    function automatic logic [W_W-1:0] random_weight();
        int unsigned p;

        p = $urandom_range(0, 99);
        if (p < 10)
            return '0;
        if (p < 20)
            return W_W'(65536);
        if (p < 25)
            return '1;
        if (p < 30)
            return W_W'($urandom_range(65537, 131070));
        return W_W'($urandom_range(0, 65536));
    endfunction

    function automatic logic [R_W-1:0] random_sample_value();
        int unsigned p;

        p = $urandom_range(0, 99);
        if (p < 5)
            return '0;
        if (p < 10)
            return '1;
        return R_W'($urandom_range(0, 65535));
    endfunction

    // one arrival: optional sender gap, then hold start until the transfer
    task automatic send_arrival(arrival_t a, logic fx, match_t outcome, int idle_pct);
        int gap;

        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 90) : $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        arr <= a;
        fixed_on <= fx;
        fixed_outcome <= outcome;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // stop sending until every outstanding result is back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (exp_wr != exp_rd)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        arrival_t a;
        int ph;
        int sent;
        int seq_len;
        int span;
        int j;
        int k;
        logic [V_W-1:0] base;

        directed_rows = '{
            // no candidates straight after a first arrival
            row(1, CNT_NONE, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0),
            // single candidate, then the same one again once taken
            row(1, CNT_ONE, 0, 1023, 1023, 65536, 131071, 131071, 65535, 1, 1, 0),
            row(0, CNT_ONE, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0),
            row(0, CNT_ONE, 1023, 0, 0, 0, 0, 0, 0, 1, 1, 1023),
            // two zero weights: first leads
            row(0, CNT_TWO, 5, 6, 0, 0, 0, 0, 65535, 1, 1, 5),
            row(0, CNT_TWO, 5, 6, 0, 65536, 0, 0, 0, 1, 1, 6),
            row(0, CNT_TWO, 7, 8, 0, 0, 65536, 0, 1, 0, 0, 0),
            // comparison exactly on the boundary and one step past it
            row(0, CNT_TWO, 9, 10, 0, 65536, 65536, 0, 32768, 0, 0, 0),
            row(0, CNT_TWO, 11, 12, 0, 65536, 65536, 0, 32769, 0, 0, 0),
            row(0, CNT_TWO, 13, 14, 0, 131071, 1, 0, 65535, 0, 0, 0),
            // all denominators zero: sample zero still reached, sample one not
            row(0, CNT_THREE, 20, 21, 22, 0, 0, 0, 0, 1, 1, 20),
            row(0, CNT_THREE, 23, 24, 25, 0, 0, 0, 1, 1, 0, 0),
            row(0, CNT_THREE, 26, 27, 28, 131071, 131071, 131071, 65535, 0, 0, 0),
            row(0, CNT_THREE, 29, 30, 31, 65536, 0, 0, 100, 0, 0, 0),
            // repeated candidate: later copies are taken
            row(0, CNT_THREE, 40, 40, 40, 1, 1, 1, 0, 1, 1, 40),
            row(0, CNT_THREE, 40, 40, 40, 1, 1, 1, 0, 1, 0, 0),
            row(0, CNT_TWO, 41, 41, 0, 5, 5, 0, 7, 0, 0, 0),
            row(0, CNT_TWO, 41, 41, 0, 5, 5, 0, 7, 1, 0, 0),
            // first arrival frees everything again
            row(1, CNT_ONE, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0),
            row(0, CNT_NONE, 1023, 1023, 1023, 131071, 131071, 131071, 65535, 1, 0, 0),
            row(0, CNT_THREE, 1023, 1023, 1023, 20000, 30000, 40000, 65535, 0, 0, 0),
            row(0, CNT_THREE, 100, 200, 300, 30000, 20000, 10000, 30000, 0, 0, 0),
            row(0, CNT_THREE, 301, 302, 303, 1000, 2000, 3000, 65535, 0, 0, 0)
        };

        // reset
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, back to back
        for (k = 0; k < N_DIRECTED; k++)
            send_arrival(directed_rows[k].arrival, directed_rows[k].fixed,
                directed_rows[k].outcome, 0);
        drain_results();

        // random arrival sequences, each opened by a first arrival unless its first item is noise
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                seq_len = $urandom_range(1, 12);
                base = V_W'($urandom_range(0, VERTICES - 1));
                k = $urandom_range(0, 9);
                span = (k < 5) ? $urandom_range(4, 16) : (k < 8) ? 64 : VERTICES;
                for (j = 0; j < seq_len; j++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        // noise: anything the fields allow
                        a.first_arrival = 1'($urandom_range(0, 1));
                        a.cand_count = CNT_W'($urandom_range(0, 3));
                        a.vertex_first = V_W'($urandom_range(0, 1023));
                        a.vertex_second = V_W'($urandom_range(0, 1023));
                        a.vertex_third = V_W'($urandom_range(0, 1023));
                    end
                    else
                    begin
                        a.first_arrival = (j == 0) || ($urandom_range(0, 32) == 0);
                        k = $urandom_range(0, 19);
                        a.cand_count = (k < 2) ? CNT_NONE : (k < 5) ? CNT_ONE :
                            (k < 10) ? CNT_TWO : CNT_THREE;
                        a.vertex_first = base + V_W'($urandom_range(0, span - 1));
                        a.vertex_second = base + V_W'($urandom_range(0, span - 1));
                        a.vertex_third = base + V_W'($urandom_range(0, span - 1));
                    end
                    a.weight_first = random_weight();
                    a.weight_second = random_weight();
                    a.weight_third = random_weight();
                    a.random_sample = random_sample_value();
                    send_arrival(a, 1'b0, '0, IDLE_PCT[ph]);
                    sent++;
                end
            end
            drain_results();
        end

        // allow for any stray result after the last one expected
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (exp_wr != exp_rd)
        begin
            $error("%0d results never arrived", exp_wr - exp_rd);
            fails++;
        end

        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // timeout
    initial
    begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
